// File: hdl/tsa_pkg.sv
`timescale 1ns / 1ps
package tsa_pkg;
   localparam int COORD_WIDTH  = 24;
   localparam int ANGLE_FRAC   = 16;
   localparam int CORDIC_STEPS = 18;
   localparam int NORM_TOP     = 58;
   localparam int MANT_W       = NORM_TOP + 1;
   localparam int CORDIC_W     = 64;
   localparam int ATAN_FRAC    = 32;
   localparam int Z_W          = 37;
   localparam logic signed [Z_W-1:0] PI_Z = 37'sd13493037704;
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
      32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
      32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
      32'd1048576,    32'd524288,     32'd262144,     32'd131072,
      32'd65536,      32'd32768,      32'd16384,      32'd8192,
      32'd4096,       32'd2048,       32'd1024,       32'd512,
      32'd256,        32'd128,        32'd64,         32'd32,
      32'd16,         32'd8,          32'd4,          32'd2
   };
endpackage

// File: hdl/tsa_isqrt.sv
`timescale 1ns / 1ps
module tsa_isqrt #(
   parameter int RW = 25,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [2*RW-1:0] in_rad [3],
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [RW-1:0] out_root [3],
   output logic [PW-1:0] out_pay
);
   localparam int RMW = RW + 2;

   logic            valid_ff [RW];
   logic [RMW-1:0]  rem_ff   [RW][3];
   logic [RW-1:0]   root_ff  [RW][3];
   logic [2*RW-1:0] rad_ff   [RW][3];
   logic [PW-1:0]   pay_ff   [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic            v_p;
      logic [RMW-1:0]  rem_p  [3];
      logic [RW-1:0]   root_p [3];
      logic [2*RW-1:0] rad_p  [3];
      logic [PW-1:0]   pay_p;
      logic [RMW+1:0]  r2     [3];
      logic [RMW+1:0]  trial  [3];
      logic [RMW+1:0]  diff   [3];

      if (k == 0) begin : g_first
         always_comb begin
            v_p   = in_valid;
            pay_p = in_pay;
            for (int j = 0; j < 3; j++) begin
               rem_p[j]  = '0;
               root_p[j] = '0;
               rad_p[j]  = in_rad[j];
            end
         end
      end else begin : g_next
         always_comb begin
            v_p   = valid_ff[k-1];
            pay_p = pay_ff[k-1];
            for (int j = 0; j < 3; j++) begin
               rem_p[j]  = rem_ff[k-1][j];
               root_p[j] = root_ff[k-1][j];
               rad_p[j]  = rad_ff[k-1][j];
            end
         end
      end

      always_comb begin
         for (int j = 0; j < 3; j++) begin
            r2[j]    = {rem_p[j], rad_p[j][2*RW-1 -: 2]};
            trial[j] = (RMW+2)'({root_p[j], 2'b01});
            diff[j]  = r2[j] - trial[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pay_ff[k] <= pay_p;
            for (int j = 0; j < 3; j++) begin
               rad_ff[k][j] <= rad_p[j] << 2;
               if (r2[j] >= trial[j]) begin
                  rem_ff[k][j]  <= diff[j][RMW-1:0];
                  root_ff[k][j] <= {root_p[j][RW-2:0], 1'b1};
               end else begin
                  rem_ff[k][j]  <= r2[j][RMW-1:0];
                  root_ff[k][j] <= {root_p[j][RW-2:0], 1'b0};
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_pay   = pay_ff[RW-1];
endmodule

// File: hdl/tsa_cordic.sv
`timescale 1ns / 1ps
module tsa_cordic #(
   parameter int VW    = 82,
   parameter int STEPS = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [VW-1:0]           in_det,
   input  logic signed [VW-1:0]           in_den,
   output logic                           out_valid,
   output logic signed [tsa_pkg::Z_W-1:0] out_z
);
   import tsa_pkg::*;

   localparam int AW  = (VW > MANT_W) ? VW : MANT_W;
   localparam int NSH = $clog2(AW);

   // sign fold and magnitudes
   logic                  dneg, xneg, zero;
   logic [VW-1:0]         xm_in, ym_in;
   logic signed [Z_W-1:0] z_in;

   logic                  pv_ff, pys_ff, phold_ff;
   logic [AW-1:0]         px_ff, py_ff;
   logic signed [Z_W-1:0] pz_ff;

   always_comb begin
      dneg  = in_det[VW-1];
      xneg  = in_den[VW-1];
      zero  = (in_det == '0);
      xm_in = xneg ? VW'(-in_den) : in_den;
      ym_in = dneg ? VW'(-in_det) : in_det;
      if (zero) begin
         z_in = xneg ? PI_Z : '0;
      end else if (xneg) begin
         z_in = dneg ? -PI_Z : PI_Z;
      end else begin
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= AW'(xm_in);
         py_ff    <= AW'(ym_in);
         pys_ff   <= xneg ? !dneg : dneg;
         pz_ff    <= z_in;
         phold_ff <= zero;
      end
   end

   // leading-zero normalization, one power-of-two shift per stage
   logic                  nv_ff    [NSH];
   logic [AW-1:0]         nx_ff    [NSH];
   logic [AW-1:0]         ny_ff    [NSH];
   logic                  nys_ff   [NSH];
   logic                  nhold_ff [NSH];
   logic signed [Z_W-1:0] nz_ff    [NSH];

   for (genvar j = 0; j < NSH; j++) begin : g_norm
      localparam int S = 1 << (NSH - 1 - j);
      logic                  v_p, ys_p, hold_p, sh;
      logic [AW-1:0]         x_p, y_p, orv;
      logic signed [Z_W-1:0] z_p;

      if (j == 0) begin : g_first
         always_comb begin
            v_p = pv_ff; x_p = px_ff; y_p = py_ff;
            ys_p = pys_ff; hold_p = phold_ff; z_p = pz_ff;
         end
      end else begin : g_next
         always_comb begin
            v_p = nv_ff[j-1]; x_p = nx_ff[j-1]; y_p = ny_ff[j-1];
            ys_p = nys_ff[j-1]; hold_p = nhold_ff[j-1]; z_p = nz_ff[j-1];
         end
      end

      always_comb begin
         orv = x_p | y_p;
         sh  = ((orv >> (AW - S)) == '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[j] <= 1'b0;
         end else if (en) begin
            nv_ff[j] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nx_ff[j]    <= sh ? (x_p << S) : x_p;
            ny_ff[j]    <= sh ? (y_p << S) : y_p;
            nys_ff[j]   <= ys_p;
            nhold_ff[j] <= hold_p;
            nz_ff[j]    <= z_p;
         end
      end
   end

   // vectoring iterations
   logic                       cv_ff    [STEPS];
   logic                       chold_ff [STEPS];
   logic signed [CORDIC_W-1:0] cx_ff    [STEPS];
   logic signed [CORDIC_W-1:0] cy_ff    [STEPS];
   logic signed [Z_W-1:0]      cz_ff    [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      logic                       v_p, hold_p;
      logic signed [CORDIC_W-1:0] x_p, y_p, xs, ys, y0;
      logic signed [Z_W-1:0]      z_p, ang;

      if (i == 0) begin : g_first
         always_comb begin
            y0     = $signed(CORDIC_W'(ny_ff[NSH-1][AW-1 -: MANT_W]));
            v_p    = nv_ff[NSH-1];
            hold_p = nhold_ff[NSH-1];
            z_p    = nz_ff[NSH-1];
            x_p    = $signed(CORDIC_W'(nx_ff[NSH-1][AW-1 -: MANT_W]));
            y_p    = nys_ff[NSH-1] ? -y0 : y0;
         end
      end else begin : g_next
         always_comb begin
            y0     = '0;
            v_p    = cv_ff[i-1];
            hold_p = chold_ff[i-1];
            z_p    = cz_ff[i-1];
            x_p    = cx_ff[i-1];
            y_p    = cy_ff[i-1];
         end
      end

      always_comb begin
         xs  = x_p >>> i;
         ys  = y_p >>> i;
         ang = $signed(Z_W'(ATAN_TAB[i]));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (en) begin
            cv_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            chold_ff[i] <= hold_p;
            if (hold_p) begin
               cx_ff[i] <= x_p;
               cy_ff[i] <= y_p;
               cz_ff[i] <= z_p;
            end else if (!y_p[CORDIC_W-1]) begin
               cx_ff[i] <= x_p + ys;
               cy_ff[i] <= y_p - xs;
               cz_ff[i] <= z_p + ang;
            end else begin
               cx_ff[i] <= x_p - ys;
               cy_ff[i] <= y_p + xs;
               cz_ff[i] <= z_p - ang;
            end
         end
      end
   end

   assign out_valid = cv_ff[STEPS-1];
   assign out_z     = cz_ff[STEPS-1];
endmodule

// File: hdl/triangle_solid_angle.sv
`timescale 1ns / 1ps
// channel   dir  signals                         transaction
// req_      in   tvalid tready tdata             a_x..c_z, p_x..p_z
// rsp_      out  tvalid tready tdata             half_solid_angle
//
// one transaction per cycle while the output is not stalled
// reset clears every stage valid bit; data registers are not reset
// a stalled output freezes the whole pipeline in place
module triangle_solid_angle #(
   parameter int COORD_WIDTH  = tsa_pkg::COORD_WIDTH,
   parameter int ANGLE_FRAC   = tsa_pkg::ANGLE_FRAC,
   parameter int CORDIC_STEPS = tsa_pkg::CORDIC_STEPS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // half_solid_angle, zero pad
   output logic [((ANGLE_FRAC+3+7)/8)*8-1:0]   rsp_tdata
);
   import tsa_pkg::*;

   localparam int D    = COORD_WIDTH + 1;
   localparam int P    = 2 * D;
   localparam int H    = D + 1;
   localparam int CRW  = 2 * D + 1;
   localparam int DW   = 2 * D + 2;
   localparam int W    = 3 * D + 4;
   localparam int LPW  = D + H + 1;
   localparam int DLW  = 2 * D + 3;
   localparam int DHW  = 2 * D + 2;
   localparam int PW   = W + 3 * DW;
   localparam int OW   = ANGLE_FRAC + 3;
   localparam int ORW  = ((OW + 7) / 8) * 8;
   localparam int SH   = ATAN_FRAC - ANGLE_FRAC;
   localparam longint PI_QV = (64'sd13493037704 + (64'sd1 <<< (SH - 1))) >>> SH;
   localparam logic [Z_W-1:0] PI_QZ = Z_W'(PI_QV);
   localparam logic [Z_W-1:0] HALF  = Z_W'(1) << (SH - 1);

   logic en;
   logic signed [COORD_WIDTH-1:0] crd [12];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int f = 0; f < 12; f++) begin
         crd[f] = req_tdata[f*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   // edge vectors
   logic                s1_v_ff;
   logic signed [D-1:0] s1_a_ff [3];
   logic signed [D-1:0] s1_b_ff [3];
   logic signed [D-1:0] s1_c_ff [3];

   // products
   logic                s2_v_ff;
   logic signed [P-1:0] s2_sq_ff [3][3];
   logic signed [P-1:0] s2_cp_ff [6];
   logic signed [P-1:0] s2_dp_ff [3][3];
   logic signed [D-1:0] s2_a_ff  [3];

   // sums
   logic                  s3_v_ff;
   logic [P-1:0]          s3_ss_ff  [3];
   logic signed [CRW-1:0] s3_cr_ff  [3];
   logic signed [DW-1:0]  s3_dot_ff [3];
   logic signed [D-1:0]   s3_a_ff   [3];

   // triple product partial products
   logic                  s4_v_ff;
   logic signed [LPW-1:0] s4_lo_ff  [3];
   logic signed [P-1:0]   s4_hi_ff  [3];
   logic [P-1:0]          s4_ss_ff  [3];
   logic signed [DW-1:0]  s4_dot_ff [3];

   logic                  s5_v_ff;
   logic signed [W-1:0]   s5_t_ff   [3];
   logic [P-1:0]          s5_ss_ff  [3];
   logic signed [DW-1:0]  s5_dot_ff [3];

   logic                  s6_v_ff;
   logic signed [W-1:0]   s6_det_ff;
   logic [P-1:0]          s6_ss_ff  [3];
   logic signed [DW-1:0]  s6_dot_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_a_ff[k] <= D'(crd[k])     - D'(crd[9+k]);
            s1_b_ff[k] <= D'(crd[3+k])   - D'(crd[9+k]);
            s1_c_ff[k] <= D'(crd[6+k])   - D'(crd[9+k]);
         end

         for (int k = 0; k < 3; k++) begin
            s2_sq_ff[0][k] <= P'(s1_a_ff[k]) * P'(s1_a_ff[k]);
            s2_sq_ff[1][k] <= P'(s1_b_ff[k]) * P'(s1_b_ff[k]);
            s2_sq_ff[2][k] <= P'(s1_c_ff[k]) * P'(s1_c_ff[k]);
            s2_dp_ff[0][k] <= P'(s1_a_ff[k]) * P'(s1_b_ff[k]);
            s2_dp_ff[1][k] <= P'(s1_b_ff[k]) * P'(s1_c_ff[k]);
            s2_dp_ff[2][k] <= P'(s1_c_ff[k]) * P'(s1_a_ff[k]);
            s2_a_ff[k]     <= s1_a_ff[k];
         end
         s2_cp_ff[0] <= P'(s1_b_ff[1]) * P'(s1_c_ff[2]);
         s2_cp_ff[1] <= P'(s1_b_ff[2]) * P'(s1_c_ff[1]);
         s2_cp_ff[2] <= P'(s1_b_ff[2]) * P'(s1_c_ff[0]);
         s2_cp_ff[3] <= P'(s1_b_ff[0]) * P'(s1_c_ff[2]);
         s2_cp_ff[4] <= P'(s1_b_ff[0]) * P'(s1_c_ff[1]);
         s2_cp_ff[5] <= P'(s1_b_ff[1]) * P'(s1_c_ff[0]);

         for (int k = 0; k < 3; k++) begin
            s3_ss_ff[k]  <= $unsigned(s2_sq_ff[k][0]) + $unsigned(s2_sq_ff[k][1])
                          + $unsigned(s2_sq_ff[k][2]);
            s3_cr_ff[k]  <= CRW'(s2_cp_ff[2*k]) - CRW'(s2_cp_ff[2*k+1]);
            s3_dot_ff[k] <= DW'(s2_dp_ff[k][0]) + DW'(s2_dp_ff[k][1])
                          + DW'(s2_dp_ff[k][2]);
            s3_a_ff[k]   <= s2_a_ff[k];
         end

         for (int k = 0; k < 3; k++) begin
            s4_lo_ff[k]  <= LPW'(s3_a_ff[k])
                          * LPW'($signed({1'b0, s3_cr_ff[k][H-1:0]}));
            s4_hi_ff[k]  <= P'(s3_a_ff[k]) * P'($signed(s3_cr_ff[k][CRW-1:H]));
            s4_ss_ff[k]  <= s3_ss_ff[k];
            s4_dot_ff[k] <= s3_dot_ff[k];
         end

         for (int k = 0; k < 3; k++) begin
            s5_t_ff[k]   <= (W'(s4_hi_ff[k]) <<< H) + W'(s4_lo_ff[k]);
            s5_ss_ff[k]  <= s4_ss_ff[k];
            s5_dot_ff[k] <= s4_dot_ff[k];
         end

         s6_det_ff <= s5_t_ff[0] + s5_t_ff[1] + s5_t_ff[2];
         s6_ss_ff  <= s5_ss_ff;
         s6_dot_ff <= s5_dot_ff;
      end
   end

   // norms
   logic          sq_v;
   logic [D-1:0]  sq_root [3];
   logic [PW-1:0] sq_pay;
   logic [PW-1:0] sq_pay_in;

   assign sq_pay_in = {s6_det_ff, s6_dot_ff[0], s6_dot_ff[1], s6_dot_ff[2]};

   tsa_isqrt #(
      .RW (D),
      .PW (PW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_v_ff),
      .in_rad    (s6_ss_ff),
      .in_pay    (sq_pay_in),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_pay   (sq_pay)
   );

   logic signed [W-1:0]  sq_det;
   logic signed [DW-1:0] sq_dot [3];
   logic [D-1:0]         sq_fac [3];

   always_comb begin
      sq_det    = sq_pay[PW-1 -: W];
      sq_dot[0] = sq_pay[3*DW-1 -: DW];
      sq_dot[1] = sq_pay[2*DW-1 -: DW];
      sq_dot[2] = sq_pay[DW-1:0];
      sq_fac[0] = sq_root[2];
      sq_fac[1] = sq_root[0];
      sq_fac[2] = sq_root[1];
   end

   // denominator
   logic                  t1_v_ff;
   logic [P-1:0]          t1_nab_ff;
   logic [D-1:0]          t1_nc_ff;
   logic signed [DLW-1:0] t1_dl_ff [3];
   logic signed [DHW-1:0] t1_dh_ff [3];
   logic signed [W-1:0]   t1_det_ff;

   logic                  t2_v_ff;
   logic [P-1:0]          t2_lo_ff, t2_hi_ff;
   logic signed [W-1:0]   t2_dt_ff [3];
   logic signed [W-1:0]   t2_det_ff;

   logic                  t3_v_ff;
   logic signed [W-1:0]   t3_nabc_ff, t3_s1_ff, t3_dt_ff, t3_det_ff;

   logic                  t4_v_ff;
   logic signed [W-1:0]   t4_s1_ff, t4_s2_ff, t4_det_ff;

   logic                  t5_v_ff;
   logic signed [W-1:0]   t5_den_ff, t5_det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
         t4_v_ff <= 1'b0;
         t5_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= sq_v;
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
         t4_v_ff <= t3_v_ff;
         t5_v_ff <= t4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_nab_ff <= P'(sq_root[0]) * P'(sq_root[1]);
         t1_nc_ff  <= sq_root[2];
         t1_det_ff <= sq_det;
         for (int k = 0; k < 3; k++) begin
            t1_dl_ff[k] <= DLW'($signed({1'b0, sq_fac[k]}))
                         * DLW'($signed({1'b0, sq_dot[k][H-1:0]}));
            t1_dh_ff[k] <= DHW'($signed({1'b0, sq_fac[k]}))
                         * DHW'($signed(sq_dot[k][DW-1:H]));
         end

         t2_lo_ff  <= P'(t1_nab_ff[D-1:0]) * P'(t1_nc_ff);
         t2_hi_ff  <= P'(t1_nab_ff[P-1:D]) * P'(t1_nc_ff);
         t2_det_ff <= t1_det_ff;
         for (int k = 0; k < 3; k++) begin
            t2_dt_ff[k] <= (W'(t1_dh_ff[k]) <<< H) + W'(t1_dl_ff[k]);
         end

         t3_nabc_ff <= $signed((W'(t2_hi_ff) << D) + W'(t2_lo_ff));
         t3_s1_ff   <= t2_dt_ff[0] + t2_dt_ff[1];
         t3_dt_ff   <= t2_dt_ff[2];
         t3_det_ff  <= t2_det_ff;

         t4_s1_ff  <= t3_s1_ff;
         t4_s2_ff  <= t3_nabc_ff + t3_dt_ff;
         t4_det_ff <= t3_det_ff;

         t5_den_ff <= t4_s1_ff + t4_s2_ff;
         t5_det_ff <= t4_det_ff;
      end
   end

   // angle
   logic                  cd_v;
   logic signed [Z_W-1:0] cd_z;

   tsa_cordic #(
      .VW    (W),
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t5_v_ff),
      .in_det    (t5_det_ff),
      .in_den    (t5_den_ff),
      .out_valid (cd_v),
      .out_z     (cd_z)
   );

   // round half away from zero, clamp to pi
   logic [Z_W-1:0] mag, q_rnd, q_clp;
   logic [Z_W-1:0] res_wide;
   logic           rsp_v_ff;
   logic [OW-1:0]  res_ff;
   logic [OW-1:0]  res_in;

   always_comb begin
      mag      = cd_z[Z_W-1] ? Z_W'(-cd_z) : Z_W'(cd_z);
      q_rnd    = (mag + HALF) >> SH;
      q_clp    = (q_rnd > PI_QZ) ? PI_QZ : q_rnd;
      res_wide = cd_z[Z_W-1] ? (Z_W'(0) - q_clp) : q_clp;
      res_in   = res_wide[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= cd_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = ORW'(res_ff);
endmodule
